// ===== rtl/core/ftrt_pkg.sv =====
// Shared types and constants for the file transfer receiver tracker.
// Used by ftrt_eval and file_transfer_receiver_tracker; depends on nothing.
package ftrt_pkg;

    // Protocol limits
    localparam int MaxSeq     = 4096;
    localparam int MaxPayload = 1496;

    // Derived widths
    localparam int SeqAw   = $clog2(MaxSeq);
    localparam int CntW    = SeqAw + 1;
    localparam int PlenW   = 11;
    localparam int EpochW  = 8;

    // Stream widths
    localparam int InTdataW  = 80;
    localparam int OutTdataW = 96;
    localparam int OutTuserW = 3;

    // Result status codes
    typedef enum logic [2:0] {
        ST_IGNORED      = 3'd0,
        ST_STARTED      = 3'd1,
        ST_REJECTED     = 3'd2,
        ST_STORED       = 3'd3,
        ST_DUPLICATE    = 3'd4,
        ST_OUT_OF_RANGE = 3'd5
    } status_t;

    // One received packet header
    typedef struct packed {
        logic [7:0]       first_byte;
        logic [23:0]      bytes_one_to_three;
        logic [31:0]      bytes_four_to_seven;
        logic [PlenW-1:0] payload_length;
    } item_t;

    // Transfer tracking state (the bitmap lives in memory)
    typedef struct packed {
        logic             active;
        logic [7:0]       id;
        logic [CntW-1:0]  seq_total;
        logic [PlenW-1:0] latched;
        logic [CntW-1:0]  count;
        logic [23:0]      byte_total;
    } track_t;

    // One result
    typedef struct packed {
        status_t          status;
        logic             send_ack;
        logic [6:0]       ack_transaction;
        logic [23:0]      ack_sequence;
        logic [23:0]      write_offset;
        logic [PlenW-1:0] write_length;
        logic             transfer_done;
        logic [23:0]      total_bytes;
    } result_t;

    // Bitmap side effects of one request
    typedef struct packed {
        logic mark;   // set the arrival bit of this sequence
        logic open;   // a new transfer starts: move to a fresh epoch
    } ctrl_t;

endpackage

// ===== rtl/core/ftrt_eval.sv =====
// Per-request decision logic: from one header, the tracking state and the
// arrival bit, forms the result, the next state and the bitmap actions.
// Depends on ftrt_pkg.
module ftrt_eval (
    input  ftrt_pkg::item_t   item,
    input  ftrt_pkg::track_t  track,
    input  logic              seen,
    output ftrt_pkg::track_t  track_next,
    output ftrt_pkg::result_t result,
    output ftrt_pkg::ctrl_t   ctrl
);
    import ftrt_pkg::*;

    logic [PlenW-1:0]       plen;
    logic [PlenW-1:0]       size;
    logic [CntW-1:0]        cnt_inc;
    logic [24:0]            sum;
    logic [SeqAw+PlenW-1:0] prod;
    logic [23:0]            new_total;

    // Saturated length, size to latch, counters and offset product
    always_comb
    begin
        plen = (item.payload_length > PlenW'(MaxPayload)) ?
               PlenW'(MaxPayload) : item.payload_length;
        size = (track.latched == '0) ? plen : track.latched;
        cnt_inc = track.count + CntW'(1);
        sum = {1'b0, track.byte_total} + 25'(plen);
        new_total = sum[24] ? 24'hffffff : sum[23:0];
        prod = (SeqAw+PlenW)'(item.bytes_one_to_three[SeqAw-1:0])
             * (SeqAw+PlenW)'(size);
    end

    // Request decision
    always_comb
    begin
        track_next         = track;
        result             = '0;
        result.status      = ST_IGNORED;
        result.total_bytes = track.byte_total;
        ctrl               = '0;

        if (!track.active)
        begin
            // idle: only a start command matters
            if (item.first_byte[6:0] == 7'd0)
            begin
                if (item.bytes_four_to_seven == 32'd0 ||
                    item.bytes_four_to_seven > 32'(MaxSeq))
                begin
                    result.status = ST_REJECTED;
                end
                else
                begin
                    track_next.active     = 1'b1;
                    track_next.id         = item.bytes_one_to_three[7:0];
                    track_next.seq_total  = item.bytes_four_to_seven[CntW-1:0];
                    track_next.latched    = '0;
                    track_next.count      = '0;
                    track_next.byte_total = '0;
                    ctrl.open             = 1'b1;
                    result.status         = ST_STARTED;
                    result.total_bytes    = '0;
                end
            end
        end
        else if (item.first_byte[7] && ({1'b0, item.first_byte[6:0]} == track.id))
        begin
            // data packet of this transfer
            if (item.bytes_one_to_three >= 24'(track.seq_total))
            begin
                result.status = ST_OUT_OF_RANGE;
            end
            else
            begin
                result.send_ack        = 1'b1;
                result.ack_transaction = track.id[6:0];
                result.ack_sequence    = item.bytes_one_to_three;
                if (seen)
                begin
                    result.status = ST_DUPLICATE;
                end
                else
                begin
                    ctrl.mark             = 1'b1;
                    track_next.latched    = size;
                    track_next.count      = cnt_inc;
                    track_next.byte_total = new_total;
                    result.status         = ST_STORED;
                    result.write_length   = plen;
                    result.write_offset   = (plen != '0) ? 24'(prod) : 24'd0;
                    result.total_bytes    = new_total;
                    if (cnt_inc >= track.seq_total)
                    begin
                        result.transfer_done = 1'b1;
                        track_next.active    = 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/file_transfer_receiver_tracker.sv =====
// Top level of the file transfer receiver tracker: stream ports, request
// and result registers, arrival bitmap memory. Depends on ftrt_pkg, ftrt_eval.
//
// Takes one packet header per request and returns one result per request.
// A request can be accepted every cycle unless m_axis holds a result back.
// Its result reaches m_axis through registers: the memory read is registered
// together with the request, and the decision into the result register.
// Arrivals are kept in a 4096-entry memory of 8-bit epoch tags with one
// read and one write port: a sequence has arrived when its tag equals the
// current epoch, so starting a transfer costs nothing. After reset, and on
// every 255th transfer start when the epoch wraps, a clearing pass writes
// one entry per cycle over the whole memory; s_axis_tready stays low meanwhile.
module file_transfer_receiver_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] first_byte, [31:8] bytes_one_to_three,
    // [63:32] bytes_four_to_seven, [74:64] payload_length
    input  logic [ftrt_pkg::InTdataW-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] send_ack, [7:1] ack_transaction, [31:8] ack_sequence,
    // [55:32] write_offset, [66:56] write_length, [90:67] total_bytes
    output logic [ftrt_pkg::OutTdataW-1:0]  m_axis_tdata,
    // [2:0] status
    output logic [ftrt_pkg::OutTuserW-1:0]  m_axis_tuser,
    // transfer_done
    output logic                            m_axis_tlast
);
    import ftrt_pkg::*;

    logic [EpochW-1:0] mem [MaxSeq];

    item_t             in_item;
    item_t             item_reg;
    logic              item_valid_reg;
    logic              item_valid_next;
    track_t            track_reg;
    track_t            track_next;
    result_t           result;
    result_t           result_reg;
    logic              out_valid_reg;
    ctrl_t             ctrl;
    logic [EpochW-1:0] epoch_reg;
    logic [EpochW-1:0] rdata_reg;
    logic              fwd_valid_reg;
    logic [SeqAw-1:0]  fwd_addr_reg;
    logic              clearing_reg;
    logic [SeqAw-1:0]  clear_addr_reg;
    logic              s1_adv;
    logic              s1_stall;
    logic              wrap;
    logic              accept;
    logic              seen;
    logic              mark_we;
    logic [SeqAw-1:0]  seq_addr;

    // Unpack the incoming request
    assign in_item.first_byte          = s_axis_tdata[7:0];
    assign in_item.bytes_one_to_three  = s_axis_tdata[31:8];
    assign in_item.bytes_four_to_seven = s_axis_tdata[63:32];
    assign in_item.payload_length      = s_axis_tdata[74:64];

    // Handshake and stage control
    assign s1_adv        = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s1_stall      = item_valid_reg && !s1_adv;
    assign wrap          = item_valid_reg && ctrl.open && (epoch_reg == '1);
    assign s_axis_tready = !clearing_reg && !wrap && !s1_stall;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (accept)
            item_valid_next = 1'b1;
        else if (s1_adv)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    // Arrival bit: stored tag, or the write that raced this request's read
    assign seq_addr = item_reg.bytes_one_to_three[SeqAw-1:0];
    assign seen     = (rdata_reg == epoch_reg) ||
                      (fwd_valid_reg && (fwd_addr_reg == seq_addr));
    assign mark_we  = s1_adv && ctrl.mark;

    ftrt_eval u_eval (
        .item       (item_reg),
        .track      (track_reg),
        .seen       (seen),
        .track_next (track_next),
        .result     (result),
        .ctrl       (ctrl)
    );

    // Bitmap memory: clearing pass or arrival marks, read on accept
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clear_addr_reg] <= '0;
        else if (mark_we)
            mem[seq_addr] <= epoch_reg;
        if (accept)
            rdata_reg <= mem[in_item.bytes_one_to_three[SeqAw-1:0]];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
        if (s1_adv)
            result_reg <= result;
        if (!s1_stall)
            fwd_addr_reg <= seq_addr;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            track_reg      <= '0;
            epoch_reg      <= EpochW'(1);
            fwd_valid_reg  <= 1'b0;
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (s1_adv)
                track_reg <= track_next;

            if (!s1_stall)
                fwd_valid_reg <= mark_we;

            // new transfer: next epoch, or wrap to the first one and clear
            if (s1_adv && ctrl.open)
            begin
                if (epoch_reg == '1)
                begin
                    epoch_reg      <= EpochW'(1);
                    clearing_reg   <= 1'b1;
                    clear_addr_reg <= '0;
                end
                else
                begin
                    epoch_reg <= epoch_reg + EpochW'(1);
                end
            end
            else if (clearing_reg)
            begin
                clear_addr_reg <= clear_addr_reg + SeqAw'(1);
                if (clear_addr_reg == '1)
                    clearing_reg <= 1'b0;
            end
        end
    end

    // Result packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0,
                            result_reg.total_bytes,
                            result_reg.write_length,
                            result_reg.write_offset,
                            result_reg.ack_sequence,
                            result_reg.ack_transaction,
                            result_reg.send_ack};
    assign m_axis_tuser  = result_reg.status;
    assign m_axis_tlast  = result_reg.transfer_done;

endmodule

// ===== tb/sv/file_transfer_receiver_tracker_tb.sv =====
// Self-checking testbench for file_transfer_receiver_tracker: directed header
// table, then random transfers, each result checked against a tracking model.
// Depends on ftrt_pkg and the tracker RTL.
module file_transfer_receiver_tracker_tb;

    import ftrt_pkg::*;

    // One directed request; status is typed in only where typed is set
    typedef struct {
        logic [7:0]  fb;
        logic [23:0] b13;
        logic [31:0] b47;
        logic [10:0] plen;
        bit          typed;
        status_t     status;
    } header_row_t;

    localparam int DirRows  = 25;
    // Rows from here on open a transfer that can never finish, so they run last
    localparam int WedgeRow = 22;
    // Sequence count of the one long transfer in the random part
    localparam int BigCount = 300;
    // Requests sent before the random part stops opening new transfers
    localparam int ItemGoal = 825;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InTdataW-1:0]  s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OutTdataW-1:0] m_axis_tdata;
    logic [OutTuserW-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    // Tracking model state
    bit                   trk_active;
    logic [7:0]           trk_id;
    logic [CntW-1:0]      trk_total;
    logic [PlenW-1:0]     trk_latched;
    bit [MaxSeq-1:0]      trk_map;
    logic [CntW-1:0]      trk_count;
    logic [23:0]          trk_bytes;

    result_t              header_reports[$];
    header_row_t          dir_rows [DirRows];
    int unsigned          sent_items;
    int unsigned          bad_reports;
    int unsigned          report_no;
    int unsigned          last_seq;
    bit                   big_sent;
    bit                   steady_run;

    file_transfer_receiver_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock: period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Tracks one accepted header and returns the result it must produce
    function automatic result_t track_header(item_t h);
        result_t          r;
        logic [PlenW-1:0] plen;
        logic [23:0]      seq;
        logic [24:0]      sum;
        r = '0;
        plen = (h.payload_length > MaxPayload) ? PlenW'(MaxPayload) : h.payload_length;
        if (!trk_active)
        begin
            // idle: only a start command does anything
            if (h.first_byte[6:0] == 7'd0)
            begin
                if (h.bytes_four_to_seven == 32'd0 || h.bytes_four_to_seven > MaxSeq)
                    r.status = ST_REJECTED;
                else
                begin
                    trk_active  = 1'b1;
                    trk_id      = h.bytes_one_to_three[7:0];
                    trk_total   = h.bytes_four_to_seven[CntW-1:0];
                    trk_latched = '0;
                    trk_map     = '0;
                    trk_count   = '0;
                    trk_bytes   = '0;
                    r.status    = ST_STARTED;
                end
            end
        end
        else if (h.first_byte[7] && {1'b0, h.first_byte[6:0]} == trk_id)
        begin
            seq = h.bytes_one_to_three;
            if (seq >= trk_total || seq >= MaxSeq)
                r.status = ST_OUT_OF_RANGE;
            else
            begin
                r.send_ack        = 1'b1;
                r.ack_transaction = trk_id[6:0];
                r.ack_sequence    = seq;
                if (trk_map[seq[SeqAw-1:0]])
                    r.status = ST_DUPLICATE;
                else
                begin
                    // first arrival: latch size, mark, count bytes
                    if (trk_latched == '0)
                        trk_latched = plen;
                    trk_map[seq[SeqAw-1:0]] = 1'b1;
                    trk_count++;
                    sum = {1'b0, trk_bytes} + 25'(plen);
                    trk_bytes = sum[24] ? 24'hFF_FFFF : sum[23:0];
                    r.status = ST_STORED;
                    r.write_length = plen;
                    if (plen != '0)
                        r.write_offset = seq * trk_latched;
                    if (trk_count >= trk_total)
                    begin
                        r.transfer_done = 1'b1;
                        trk_active = 1'b0;
                    end
                end
            end
        end
        r.total_bytes = trk_bytes;
        return r;
    endfunction

    // Random header shaped by the tracking state: mostly well-formed transfers
    function automatic item_t pick_header();
        item_t       h;
        int unsigned roll;
        int unsigned seq;
        h.first_byte          = 8'($urandom);
        h.bytes_one_to_three  = 24'($urandom);
        h.bytes_four_to_seven = $urandom;
        roll = $urandom_range(99);
        if (roll < 10)
            h.payload_length = '0;
        else if (roll < 20)
            h.payload_length = PlenW'($urandom_range(2047, MaxPayload + 1));
        else if (roll < 30)
            h.payload_length = PlenW'(MaxPayload);
        else
            h.payload_length = PlenW'($urandom_range(MaxPayload - 1, 1));
        roll = $urandom_range(99);
        if (!trk_active)
        begin
            if (roll < 8)
                h.first_byte[6:0] = 7'($urandom_range(127, 1));
            else
            begin
                h.first_byte[6:0] = 7'd0;
                if (roll < 11)
                    h.bytes_four_to_seven = 32'd0;
                else if (roll < 14)
                    h.bytes_four_to_seven = MaxSeq + 1;
                else if (roll < 17)
                    h.bytes_four_to_seven = $urandom_range(32'hFFFF_FFFF, MaxSeq + 1);
                else
                begin
                    // keep the id reachable by data packets
                    h.bytes_one_to_three[7] = 1'b0;
                    if (!big_sent)
                    begin
                        h.bytes_four_to_seven = BigCount;
                        big_sent = 1'b1;
                    end
                    else if (roll < 70)
                        h.bytes_four_to_seven = $urandom_range(3, 1);
                    else if (roll < 95)
                        h.bytes_four_to_seven = $urandom_range(12, 4);
                    else
                        h.bytes_four_to_seven = $urandom_range(40, 13);
                end
            end
        end
        else if (roll < 80)
        begin
            h.first_byte = {1'b1, trk_id[6:0]};
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                // next missing sequence from a random point
                seq = $urandom_range(trk_total - 1);
                while (trk_map[seq])
                    seq = (seq + 1) % trk_total;
            end
            else if (roll < 92)
                seq = roll[0] ? last_seq : $urandom_range(trk_total - 1);
            else
                seq = roll[0] ? trk_total : $urandom_range(24'hFF_FFFF, trk_total);
            last_seq = seq;
            h.bytes_one_to_three = 24'(seq);
        end
        else if (roll < 90)
            h.first_byte = {1'b1, trk_id[6:0] + 7'($urandom_range(127, 1))};
        else if (roll < 95)
            h.first_byte[7] = 1'b0;
        return h;
    endfunction

    // Drives one request from a falling edge and returns at a falling edge
    task automatic push_header(input item_t h, input bit typed, input status_t st);
        result_t r;
        while (!steady_run && $urandom_range(99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, h.payload_length, h.bytes_four_to_seven,
                          h.bytes_one_to_three, h.first_byte};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = track_header(h);
        if (typed)
        begin
            r = '0;
            r.status = st;
        end
        header_reports.push_back(r);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic push_row(input header_row_t row);
        item_t h;
        h = {row.fb, row.b13, row.b47, row.plen};
        push_header(h, row.typed, row.status);
    endtask

    // Result side stalls at random, except in the steady stretch
    always @(negedge clk)
        m_axis_tready <= steady_run || ($urandom_range(99) >= 36);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_report();
    end

    task automatic check_report();
        result_t got;
        result_t want;
        got.status          = status_t'(m_axis_tuser);
        got.send_ack        = m_axis_tdata[0];
        got.ack_transaction = m_axis_tdata[7:1];
        got.ack_sequence    = m_axis_tdata[31:8];
        got.write_offset    = m_axis_tdata[55:32];
        got.write_length    = m_axis_tdata[66:56];
        got.transfer_done   = m_axis_tlast;
        got.total_bytes     = m_axis_tdata[90:67];
        if (header_reports.size() == 0)
        begin
            if (bad_reports < 10)
                $display("report %0d: none pending, got st=%0d", report_no, got.status);
            bad_reports++;
        end
        else
        begin
            want = header_reports.pop_front();
            if (got !== want)
            begin
                if (bad_reports < 10)
                begin
                    $display("report %0d want st=%0d ack=%0b id=%0h seq=%0h off=%0h len=%0d last=%0b tot=%0d",
                             report_no, want.status, want.send_ack, want.ack_transaction,
                             want.ack_sequence, want.write_offset, want.write_length,
                             want.transfer_done, want.total_bytes);
                    $display("report %0d got  st=%0d ack=%0b id=%0h seq=%0h off=%0h len=%0d last=%0b tot=%0d",
                             report_no, got.status, got.send_ack, got.ack_transaction,
                             got.ack_sequence, got.write_offset, got.write_length,
                             got.transfer_done, got.total_bytes);
                end
                bad_reports++;
            end
        end
        report_no++;
    endtask

    // Watchdog: far above the slowest correct run, clearing passes included
    initial
    begin
        #4_000_000;
        $display("file_transfer_receiver_tracker_tb: FAIL");
        $finish;
    end

    initial
    begin
        // fb, bytes 1-3, bytes 4-7, payload length, typed, status
        dir_rows = '{
            '{8'h85, 24'h000000, 32'h0000_0000, 11'd0,    1'b1, ST_IGNORED},
            '{8'h00, 24'hFFFF05, 32'h0000_0000, 11'd2047, 1'b1, ST_REJECTED},
            '{8'h80, 24'h000005, 32'd4097,      11'd5,    1'b1, ST_REJECTED},
            '{8'h00, 24'h000005, 32'hFFFF_FFFF, 11'd0,    1'b1, ST_REJECTED},
            '{8'h00, 24'hABCD03, 32'd4,         11'd1496, 1'b1, ST_STARTED},
            '{8'h83, 24'd4,      32'h0000_0000, 11'd10,   1'b1, ST_OUT_OF_RANGE},
            '{8'h83, 24'hFFFFFF, 32'hFFFF_FFFF, 11'd2047, 1'b1, ST_OUT_OF_RANGE},
            '{8'h84, 24'd0,      32'h0000_0000, 11'd10,   1'b1, ST_IGNORED},
            '{8'h03, 24'd0,      32'h0000_0000, 11'd10,   1'b1, ST_IGNORED},
            '{8'h00, 24'h000007, 32'd2,         11'd10,   1'b1, ST_IGNORED},
            '{8'h83, 24'd1,      32'h0000_0000, 11'd0,    1'b0, ST_IGNORED},
            '{8'h83, 24'd2,      32'hFFFF_FFFF, 11'd2047, 1'b0, ST_IGNORED},
            '{8'h83, 24'd2,      32'h0000_0000, 11'd100,  1'b0, ST_IGNORED},
            '{8'h83, 24'd0,      32'h0000_0000, 11'd1,    1'b0, ST_IGNORED},
            '{8'h83, 24'd3,      32'h0000_0000, 11'd1496, 1'b0, ST_IGNORED},
            '{8'h83, 24'd0,      32'h0000_0000, 11'd50,   1'b0, ST_IGNORED},
            '{8'h7F, 24'h00007F, 32'd1,         11'd0,    1'b0, ST_IGNORED},
            '{8'h00, 24'h00007F, 32'd1,         11'd0,    1'b0, ST_IGNORED},
            '{8'hFF, 24'd0,      32'h0000_0000, 11'd0,    1'b0, ST_IGNORED},
            '{8'h80, 24'h000000, 32'd2,         11'd0,    1'b0, ST_IGNORED},
            '{8'h80, 24'd1,      32'h0000_0000, 11'd64,   1'b0, ST_IGNORED},
            '{8'h80, 24'd0,      32'h0000_0000, 11'd1000, 1'b0, ST_IGNORED},
            '{8'h00, 24'h0000FF, 32'd3,         11'd0,    1'b1, ST_STARTED},
            '{8'hFF, 24'd0,      32'h0000_0000, 11'd10,   1'b1, ST_IGNORED},
            '{8'h80, 24'd0,      32'h0000_0000, 11'd10,   1'b1, ST_IGNORED}
        };

        trk_active  = 1'b0;
        trk_id      = '0;
        trk_total   = '0;
        trk_latched = '0;
        trk_map     = '0;
        trk_count   = '0;
        trk_bytes   = '0;

        // Reset held, then released on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < WedgeRow; i++)
            push_row(dir_rows[i]);

        // Random transfers until the request budget is spent and the last one ends
        while (sent_items < ItemGoal || trk_active)
        begin
            steady_run = (sent_items >= 400 && sent_items < 520);
            push_header(pick_header(), 1'b0, ST_IGNORED);
        end
        steady_run = 1'b0;

        for (int i = WedgeRow; i < DirRows; i++)
            push_row(dir_rows[i]);
        s_axis_tvalid <= 1'b0;

        // Drain, then keep checking for stray results
        while (header_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (bad_reports == 0 && header_reports.size() == 0)
            $display("file_transfer_receiver_tracker_tb: PASS");
        else
            $display("file_transfer_receiver_tracker_tb: FAIL");
        $finish;
    end

endmodule
